// ----- design/speed_target_arbiter_macros.svh -----
// ----------------------------------------------------------------------------
// speed_target_arbiter assertion macros
// shared concurrent assertion forms, clocked on aclk, off while in reset
// ----------------------------------------------------------------------------
`ifndef SPEED_TARGET_ARBITER_MACROS_SVH
`define SPEED_TARGET_ARBITER_MACROS_SVH

// same-cycle implication
`define STA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sta_pkg.sv -----
// ----------------------------------------------------------------------------
// sta_pkg
// codes, thresholds and register reset values of the speed target arbiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sta_pkg;

    // control modes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_NONPID = 2'd1;
    localparam logic [1:0] MODE_PID    = 2'd2;

    // longitudinal phases
    localparam logic [1:0] PH_BRAKE = 2'd0;
    localparam logic [1:0] PH_IDLE  = 2'd1;
    localparam logic [1:0] PH_COAST = 2'd2;

    // flag bit positions
    localparam int FLAG_CURVE    = 0;
    localparam int FLAG_RECOVERY = 1;
    localparam int FLAG_LEAD     = 2;
    localparam int FLAG_RESUME   = 3;

    // thresholds (0.20 km/h, 0.05 brake, 0.05 m/s^2)
    localparam logic [14:0] SPEED_THRESH = 15'd13;
    localparam logic [11:0] BRAKE_THRESH = 12'd13;
    localparam logic [14:0] ACCEL_THRESH = 15'd13;

    // register reset values
    localparam logic [11:0] LOOKAHEAD_MIN_RST      = 12'd192;
    localparam logic [11:0] LOOKAHEAD_MAX_RST      = 12'd512;
    localparam logic [11:0] BASE_LOOKAHEAD_RST     = 12'd160;
    localparam logic [11:0] BASE_LOOKAHEAD_MAX_RST = 12'd384;
    localparam logic [15:0] SPEED_GAIN_RST         = 16'd2621;
    localparam logic [9:0]  ACCEL_GAIN_RST         = 10'd96;
    localparam logic [11:0] ACCEL_CAP_RST          = 12'd512;
    localparam logic [11:0] DECEL_MARGIN_RST       = 12'd128;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LOOKAHEAD_MIN      = 3'd0,
        CFG_LOOKAHEAD_MAX      = 3'd1,
        CFG_BASE_LOOKAHEAD     = 3'd2,
        CFG_BASE_LOOKAHEAD_MAX = 3'd3,
        CFG_SPEED_GAIN         = 3'd4,
        CFG_ACCEL_GAIN         = 3'd5,
        CFG_ACCEL_CAP          = 3'd6,
        CFG_DECEL_MARGIN       = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        DEC_OFF       = 3'd0,
        DEC_NONPID    = 3'd1,
        DEC_ZERO      = 3'd2,
        DEC_PASS      = 3'd3,
        DEC_BELOW     = 3'd4,
        DEC_HELD      = 3'd5,
        DEC_LOOKAHEAD = 3'd6
    } decision_t;

endpackage

`default_nettype wire

// ----- design/speed_target_arbiter.sv -----
// Speed target arbiter. Takes one command word per clock and returns one
// result word per command, passed in order through an input
// register, a product register holding the two gain multiplies and the
// chosen raw target, and the result register. All three stages advance
// independently, so the sustained rate is one word per cycle; a stall on
// the result side backs up through the stages and drops s_ready only once
// every stage is full. Configuration writes take effect on the next edge
// and are expected only while no command is in flight.
// ----------------------------------------------------------------------------
// speed_target_arbiter
// selects the actuator speed target from supervisor, curve, recovery, lead
// and cruise inputs; in PID mode capped by the held speed or a speed and acceleration lookahead
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "speed_target_arbiter_macros.svh"

module speed_target_arbiter (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [sta_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [sta_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // command channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_control_mode,
    input  wire logic [1:0]                         s_phase,
    input  wire logic [3:0]                         s_flags,
    input  wire logic [11:0]                        s_brake_level,
    input  wire logic signed [15:0]                 s_supervisor_speed,
    input  wire logic signed [15:0]                 s_recovery_target,
    input  wire logic signed [15:0]                 s_lead_target,
    input  wire logic signed [15:0]                 s_cruise_speed,
    input  wire logic signed [15:0]                 s_ego_speed,
    input  wire logic signed [15:0]                 s_accel_cmd,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [14:0]                             m_target_speed,
    output logic [2:0]                              m_decision
);

    // ---------------- configuration registers ----------------
    logic [11:0] lookahead_min_reg, lookahead_max_reg;
    logic [11:0] base_lookahead_reg, base_lookahead_max_reg;
    logic [15:0] speed_gain_reg;
    logic [9:0]  accel_gain_reg;
    logic [11:0] accel_cap_reg, decel_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookahead_min_reg      <= sta_pkg::LOOKAHEAD_MIN_RST;
            lookahead_max_reg      <= sta_pkg::LOOKAHEAD_MAX_RST;
            base_lookahead_reg     <= sta_pkg::BASE_LOOKAHEAD_RST;
            base_lookahead_max_reg <= sta_pkg::BASE_LOOKAHEAD_MAX_RST;
            speed_gain_reg         <= sta_pkg::SPEED_GAIN_RST;
            accel_gain_reg         <= sta_pkg::ACCEL_GAIN_RST;
            accel_cap_reg          <= sta_pkg::ACCEL_CAP_RST;
            decel_margin_reg       <= sta_pkg::DECEL_MARGIN_RST;
        end else if (cfg_wr_en) begin
            case (sta_pkg::cfg_idx_t'(cfg_addr))
                sta_pkg::CFG_LOOKAHEAD_MIN:      lookahead_min_reg      <= cfg_wdata[11:0];
                sta_pkg::CFG_LOOKAHEAD_MAX:      lookahead_max_reg      <= cfg_wdata[11:0];
                sta_pkg::CFG_BASE_LOOKAHEAD:     base_lookahead_reg     <= cfg_wdata[11:0];
                sta_pkg::CFG_BASE_LOOKAHEAD_MAX: base_lookahead_max_reg <= cfg_wdata[11:0];
                sta_pkg::CFG_SPEED_GAIN:         speed_gain_reg         <= cfg_wdata[15:0];
                sta_pkg::CFG_ACCEL_GAIN:         accel_gain_reg         <= cfg_wdata[9:0];
                sta_pkg::CFG_ACCEL_CAP:          accel_cap_reg          <= cfg_wdata[11:0];
                sta_pkg::CFG_DECEL_MARGIN:       decel_margin_reg       <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, p2_valid_reg, out_valid_reg;
    logic out_ready, p2_ready, s1_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || p2_ready;
    assign s_ready   = s1_ready;
    assign m_valid   = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready)  s1_valid_reg  <= s_valid;
            if (p2_ready)  p2_valid_reg  <= s1_valid_reg;
            if (out_ready) out_valid_reg <= p2_valid_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic [1:0]         s1_mode_reg, s1_phase_reg;
    logic [3:0]         s1_flags_reg;
    logic [11:0]        s1_brake_reg;
    logic signed [15:0] s1_sup_reg, s1_rec_reg, s1_lead_reg;
    logic signed [15:0] s1_cruise_reg, s1_ego_reg, s1_acc_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s1_ready) begin
            s1_mode_reg   <= s_control_mode;
            s1_phase_reg  <= s_phase;
            s1_flags_reg  <= s_flags;
            s1_brake_reg  <= s_brake_level;
            s1_sup_reg    <= s_supervisor_speed;
            s1_rec_reg    <= s_recovery_target;
            s1_lead_reg   <= s_lead_target;
            s1_cruise_reg <= s_cruise_speed;
            s1_ego_reg    <= s_ego_speed;
            s1_acc_reg    <= s_accel_cmd;
        end
    end

    // selection and gain products
    logic [14:0] sup_nn, ego_nn;
    logic        rec_ok, lead_ok, cruise_ok, curve_ok;
    logic [15:0] lead_plus_margin;
    logic [14:0] pick;
    logic [11:0] acc_clamped;
    logic [30:0] sl_full;
    logic [21:0] al_full;

    sta_pkg::decision_t p2_dec_next;
    logic               p2_pid_next;
    logic [14:0]        p2_raw_next;
    logic               p2_acc_hi_next;

    always_comb begin
        sup_nn = s1_sup_reg[15] ? 15'd0 : s1_sup_reg[14:0];
        ego_nn = s1_ego_reg[15] ? 15'd0 : s1_ego_reg[14:0];

        curve_ok  = s1_flags_reg[sta_pkg::FLAG_CURVE] && (sup_nn > sta_pkg::SPEED_THRESH);
        rec_ok    = s1_flags_reg[sta_pkg::FLAG_RECOVERY] && !s1_rec_reg[15]
                    && (s1_rec_reg[14:0] > sta_pkg::SPEED_THRESH);
        // lead only matters once positive, so its low bits suffice for the sum
        lead_plus_margin = {1'b0, s1_lead_reg[14:0]} + {4'd0, decel_margin_reg};
        lead_ok   = s1_flags_reg[sta_pkg::FLAG_LEAD] && !s1_lead_reg[15]
                    && (s1_lead_reg[14:0] > sta_pkg::SPEED_THRESH)
                    && (lead_plus_margin < {1'b0, ego_nn});
        cruise_ok = !s1_cruise_reg[15] && (s1_cruise_reg[14:0] > sta_pkg::SPEED_THRESH);

        if (curve_ok)       pick = sup_nn;
        else if (rec_ok)    pick = s1_rec_reg[14:0];
        else if (lead_ok)   pick = s1_lead_reg[14:0];
        else if (cruise_ok) pick = s1_cruise_reg[14:0];
        else                pick = sup_nn;

        p2_acc_hi_next = !s1_acc_reg[15] && (s1_acc_reg[14:0] > sta_pkg::ACCEL_THRESH);
        if (s1_acc_reg[15])
            acc_clamped = 12'd0;
        else if (s1_acc_reg[14:0] > {3'd0, accel_cap_reg})
            acc_clamped = accel_cap_reg;
        else
            acc_clamped = s1_acc_reg[11:0];

        sl_full = {16'd0, ego_nn} * {15'd0, speed_gain_reg};
        al_full = {12'd0, accel_gain_reg} * {10'd0, acc_clamped};

        p2_pid_next = 1'b0;
        if (s1_mode_reg == sta_pkg::MODE_OFF) begin
            p2_dec_next = sta_pkg::DEC_OFF;
            p2_raw_next = 15'd0;
        end else if (s1_mode_reg != sta_pkg::MODE_PID) begin
            p2_dec_next = sta_pkg::DEC_NONPID;
            p2_raw_next = sup_nn;
        end else if (s1_brake_reg > sta_pkg::BRAKE_THRESH || s1_phase_reg == sta_pkg::PH_BRAKE
                     || s1_phase_reg == sta_pkg::PH_IDLE) begin
            p2_dec_next = sta_pkg::DEC_ZERO;
            p2_raw_next = 15'd0;
        end else if (s1_phase_reg == sta_pkg::PH_COAST
                     || s1_flags_reg[sta_pkg::FLAG_RESUME]) begin
            p2_dec_next = sta_pkg::DEC_PASS;
            p2_raw_next = sup_nn;
        end else begin
            // final code settled in the next stage
            p2_dec_next = sta_pkg::DEC_BELOW;
            p2_raw_next = pick;
            p2_pid_next = 1'b1;
        end
    end

    // ---------------- stage 2: product register ----------------
    sta_pkg::decision_t p2_dec_reg;
    logic               p2_pid_reg, p2_acc_hi_reg;
    logic [14:0]        p2_raw_reg, p2_ego_reg, p2_sup_reg, p2_sl_prod_reg;
    logic [13:0]        p2_al_reg;

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && p2_ready) begin
            p2_dec_reg     <= p2_dec_next;
            p2_pid_reg     <= p2_pid_next;
            p2_acc_hi_reg  <= p2_acc_hi_next;
            p2_raw_reg     <= p2_raw_next;
            p2_ego_reg     <= ego_nn;
            p2_sup_reg     <= sup_nn;
            p2_sl_prod_reg <= sl_full[30:16];
            p2_al_reg      <= al_full[21:8];
        end
    end

    // lookahead clamps and final pick
    logic [15:0] sl_sum, sl_lo;
    logic [11:0] sl_c;
    logic [14:0] la_sum, la_lo;
    logic [11:0] la_c;
    logic [15:0] ego_plus_la;
    logic [14:0] held_cap;

    sta_pkg::decision_t out_dec_next;
    logic [14:0]        out_target_next;

    always_comb begin
        sl_sum = {1'b0, p2_sl_prod_reg} + {4'd0, base_lookahead_reg};
        sl_lo  = (sl_sum < {4'd0, base_lookahead_reg}) ? {4'd0, base_lookahead_reg} : sl_sum;
        // upper bound applied last, so the result never exceeds it
        sl_c   = (sl_lo > {4'd0, base_lookahead_max_reg}) ? base_lookahead_max_reg
                                                          : sl_lo[11:0];
        la_sum = {3'd0, sl_c} + {1'b0, p2_al_reg};
        la_lo  = (la_sum < {3'd0, lookahead_min_reg}) ? {3'd0, lookahead_min_reg} : la_sum;
        la_c   = (la_lo > {3'd0, lookahead_max_reg}) ? lookahead_max_reg : la_lo[11:0];
        ego_plus_la = {1'b0, p2_ego_reg} + {4'd0, la_c};
        held_cap    = (p2_ego_reg > p2_sup_reg) ? p2_ego_reg : p2_sup_reg;

        if (!p2_pid_reg) begin
            out_dec_next    = p2_dec_reg;
            out_target_next = p2_raw_reg;
        end else if (p2_raw_reg <= p2_ego_reg) begin
            out_dec_next    = sta_pkg::DEC_BELOW;
            out_target_next = p2_raw_reg;
        end else if (!p2_acc_hi_reg) begin
            out_dec_next    = sta_pkg::DEC_HELD;
            out_target_next = (p2_raw_reg < held_cap) ? p2_raw_reg : held_cap;
        end else begin
            out_dec_next    = sta_pkg::DEC_LOOKAHEAD;
            out_target_next = ({1'b0, p2_raw_reg} < ego_plus_la) ? p2_raw_reg
                                                                  : ego_plus_la[14:0];
        end
    end

    // ---------------- stage 3: result register ----------------
    sta_pkg::decision_t out_dec_reg;
    logic [14:0]        out_target_reg;

    always_ff @(posedge aclk) begin
        if (p2_valid_reg && out_ready) begin
            out_dec_reg    <= out_dec_next;
            out_target_reg <= out_target_next;
        end
    end

    assign m_target_speed = out_target_reg;
    assign m_decision     = out_dec_reg;

    // ---------------- assertions ----------------
    `STA_ASSERT_IMPL(a_zero_target,
        m_valid && (m_decision == sta_pkg::DEC_OFF || m_decision == sta_pkg::DEC_ZERO),
        m_target_speed == 15'd0, "zero decision with nonzero target")
    `STA_ASSERT_NEXT(a_in_to_s1, s_valid && s_ready, s1_valid_reg,
        "accepted word not held in input stage")
    `STA_ASSERT_NEXT(a_p2_to_out, p2_valid_reg && out_ready, out_valid_reg,
        "product stage word lost on the way to the result register")

endmodule

`default_nettype wire
